// ===== rtl/core/aar_pkg.sv =====
package aar_pkg;

  localparam int CORDIC_STAGES_DEF = 20;
  localparam int CORDIC_STAGES_MAX = 30;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] REG_AXIS_X   = 3'd0;
  localparam logic [2:0] REG_AXIS_Y   = 3'd1;
  localparam logic [2:0] REG_AXIS_Z   = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;
  localparam logic [2:0] REG_CENTER_Z = 3'd5;
  localparam logic [2:0] REG_ANGLE    = 3'd6;

  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] DEG2RAD_Q32 = 34'sd74961321;
  localparam logic signed [27:0] DEG90       = 28'sd5898240;
  localparam logic signed [27:0] DEG180      = 28'sd11796480;
  localparam logic signed [27:0] DEG360      = 28'sd23592960;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic [8:0][31:0] m;   // row-major Q2.30 matrix, clamped to +-1.0
    logic             zero;
  } coef_t;

  typedef struct packed {
    logic [2:0][31:0] p;   // point, z y x from msb
    logic [2:0][32:0] d;   // point minus center
  } item_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return $signed({2'b00, v});
  endfunction

  // arithmetic right shift, rounded half away from zero
  function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v,
                                                   input int unsigned s);
    logic signed [67:0] half;
    logic signed [67:0] b;
    half = 68'sd1 <<< (s - 1);
    b = v + half - $signed({67'd0, v[67]});
    return b >>> s;
  endfunction

  function automatic logic signed [31:0] clamp1(input logic signed [35:0] v);
    if (v > 36'sd1073741824) return 32'sd1073741824;
    if (v < -36'sd1073741824) return -32'sd1073741824;
    return 32'(v);
  endfunction

endpackage

// ===== rtl/core/aar_coef.sv =====
module aar_coef #(
  parameter int CORDIC_STAGES = aar_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  axis_x,
  input  logic signed [31:0]  axis_y,
  input  logic signed [31:0]  axis_z,
  input  logic signed [25:0]  angle_deg,
  output aar_pkg::coef_t      coef,
  output logic                ready
);
  import aar_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SHIFT = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_DVI   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DVE   = 4'd7;
  localparam logic [3:0] S_ANG   = 4'd8;
  localparam logic [3:0] S_COR   = 4'd9;
  localparam logic [3:0] S_CS    = 4'd10;
  localparam logic [3:0] S_MAT   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  localparam logic [5:0] COR_LAST = 6'(CORDIC_STAGES - 1);

  logic [3:0]         state;
  logic               ph;
  logic [5:0]         cnt;
  logic [1:0]         comp;
  logic [31:0]        mag [3];
  logic [2:0]         sgn;
  logic [31:0]        mx;
  logic               zero;
  logic [63:0]        n2;
  logic [63:0]        sq_n;
  logic [63:0]        sq_r;
  logic [63:0]        sq_bit;
  logic [31:0]        norm;
  logic [61:0]        num;
  logic [31:0]        rem;
  logic [30:0]        quot;
  logic signed [31:0] u [3];
  logic               neg;
  logic signed [33:0] z;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [33:0] cc;
  logic signed [33:0] ss;
  logic signed [33:0] slot [15];
  logic signed [67:0] mul_p;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [33:0] t;
  logic [31:0]        abs_x, abs_y, abs_z, abs_max;
  logic signed [27:0] deg0, deg1, degf;
  logic               negf;
  logic [64:0]        sq_sum;
  logic [32:0]        dsh;
  logic               dge;
  logic signed [33:0] dx, dy, at;

  always_comb begin
    abs_x = axis_x[31] ? 32'(-axis_x) : axis_x;
    abs_y = axis_y[31] ? 32'(-axis_y) : axis_y;
    abs_z = axis_z[31] ? 32'(-axis_z) : axis_z;
    abs_max = abs_x;
    if (abs_y > abs_max) abs_max = abs_y;
    if (abs_z > abs_max) abs_max = abs_z;

    deg0 = 28'(angle_deg);
    deg1 = deg0;
    if (deg0 > DEG180) deg1 = deg0 - DEG360;
    else if (deg0 < -DEG180) deg1 = deg0 + DEG360;
    degf = deg1;
    negf = 1'b0;
    if (deg1 > DEG90) begin
      degf = deg1 - DEG180;
      negf = 1'b1;
    end else if (deg1 < -DEG90) begin
      degf = deg1 + DEG180;
      negf = 1'b1;
    end

    sq_sum = {1'b0, sq_r} + {1'b0, sq_bit};
    dsh = {rem, num[61]};
    dge = dsh >= {1'b0, norm};
    dx = cy >>> cnt[4:0];
    dy = cx >>> cnt[4:0];
    at = atan_q30(cnt[4:0]);
    t = Q30_ONE - cc;

    mul_a = '0;
    mul_b = '0;
    if (state == S_SQ) begin
      mul_a = $signed({2'b00, mag[cnt[1:0]]});
      mul_b = mul_a;
    end else if (state == S_ANG) begin
      mul_a = 34'(degf);
      mul_b = DEG2RAD_Q32;
    end else if (state == S_MAT) begin
      case (cnt)
        6'd0:  begin mul_a = 34'(u[0]); mul_b = 34'(u[0]); end
        6'd1:  begin mul_a = 34'(u[1]); mul_b = 34'(u[1]); end
        6'd2:  begin mul_a = 34'(u[2]); mul_b = 34'(u[2]); end
        6'd3:  begin mul_a = 34'(u[0]); mul_b = 34'(u[1]); end
        6'd4:  begin mul_a = 34'(u[0]); mul_b = 34'(u[2]); end
        6'd5:  begin mul_a = 34'(u[1]); mul_b = 34'(u[2]); end
        6'd6:  begin mul_a = slot[0];   mul_b = t; end
        6'd7:  begin mul_a = slot[1];   mul_b = t; end
        6'd8:  begin mul_a = slot[2];   mul_b = t; end
        6'd9:  begin mul_a = slot[3];   mul_b = t; end
        6'd10: begin mul_a = slot[4];   mul_b = t; end
        6'd11: begin mul_a = slot[5];   mul_b = t; end
        6'd12: begin mul_a = 34'(u[0]); mul_b = ss; end
        6'd13: begin mul_a = 34'(u[1]); mul_b = ss; end
        6'd14: begin mul_a = 34'(u[2]); mul_b = ss; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph <= 1'b0;
      cnt <= '0;
      comp <= '0;
    end else if (start) begin
      mag[0] <= abs_x;
      mag[1] <= abs_y;
      mag[2] <= abs_z;
      sgn <= {axis_z[31], axis_y[31], axis_x[31]};
      mx <= abs_max;
      zero <= (abs_max == 32'd0);
      n2 <= '0;
      ph <= 1'b0;
      cnt <= '0;
      comp <= '0;
      state <= (abs_max == 32'd0) ? S_FIN : S_SHIFT;
    end else begin
      unique case (state)
        S_IDLE: ;
        S_SHIFT: begin
          if (mx[31:30] == 2'b00) begin
            mx <= mx << 1;
            mag[0] <= mag[0] << 1;
            mag[1] <= mag[1] << 1;
            mag[2] <= mag[2] << 1;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          ph <= ~ph;
          if (ph) begin
            n2 <= n2 + mul_p[63:0];
            cnt <= cnt + 6'd1;
            if (cnt == 6'd2) begin
              sq_n <= n2 + mul_p[63:0];
              sq_r <= '0;
              sq_bit <= 64'd1 << 62;
              cnt <= '0;
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if ({1'b0, sq_n} >= sq_sum) begin
            sq_n <= sq_n - sq_sum[63:0];
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) state <= S_NORM;
        end
        S_NORM: begin
          norm <= sq_r[31:0];
          state <= S_DVI;
        end
        S_DVI: begin
          num <= ({30'd0, mag[comp]} << 30) + {31'd0, norm[31:1]};
          rem <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= dge ? 32'(dsh - {1'b0, norm}) : dsh[31:0];
          quot <= {quot[29:0], dge};
          num <= num << 1;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd61) state <= S_DVE;
        end
        S_DVE: begin
          u[comp] <= sgn[comp] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
          if (comp == 2'd2) begin
            ph <= 1'b0;
            state <= S_ANG;
          end else begin
            comp <= comp + 2'd1;
            state <= S_DVI;
          end
        end
        S_ANG: begin
          ph <= ~ph;
          if (!ph) begin
            neg <= negf;
          end else begin
            z <= 34'(rnd_shift(mul_p, 18));
            cx <= CORDIC_GAIN;
            cy <= '0;
            cnt <= '0;
            state <= S_COR;
          end
        end
        S_COR: begin
          if (!z[33]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            z <= z - at;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            z <= z + at;
          end
          cnt <= cnt + 6'd1;
          if (cnt == COR_LAST) state <= S_CS;
        end
        S_CS: begin
          cc <= neg ? -cx : cx;
          ss <= neg ? -cy : cy;
          cnt <= '0;
          ph <= 1'b0;
          state <= S_MAT;
        end
        S_MAT: begin
          ph <= ~ph;
          if (ph) begin
            slot[cnt[3:0]] <= 34'(rnd_shift(mul_p, 30));
            cnt <= cnt + 6'd1;
            if (cnt == 6'd14) state <= S_FIN;
          end
        end
        S_FIN: begin
          coef.zero <= zero;
          coef.m[0] <= clamp1(36'(slot[6]) + 36'(cc));
          coef.m[1] <= clamp1(36'(slot[9]) - 36'(slot[14]));
          coef.m[2] <= clamp1(36'(slot[10]) + 36'(slot[13]));
          coef.m[3] <= clamp1(36'(slot[9]) + 36'(slot[14]));
          coef.m[4] <= clamp1(36'(slot[7]) + 36'(cc));
          coef.m[5] <= clamp1(36'(slot[11]) - 36'(slot[12]));
          coef.m[6] <= clamp1(36'(slot[10]) - 36'(slot[13]));
          coef.m[7] <= clamp1(36'(slot[11]) + 36'(slot[12]));
          coef.m[8] <= clamp1(36'(slot[8]) + 36'(cc));
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ready = (state == S_IDLE);

endmodule

// ===== rtl/core/aar_queue.sv =====
module aar_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  aar_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output aar_pkg::item_t pop_item
);
  import aar_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = mem[rptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/core/aar_xform.sv =====
module aar_xform (
  input  logic               clk,
  input  logic               rst,
  input  aar_pkg::coef_t     coef,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  aar_pkg::item_t     pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rotated_x,
  output logic signed [31:0] rotated_y,
  output logic signed [31:0] rotated_z,
  output logic               axis_zero,
  output logic               clipped
);
  import aar_pkg::*;

  logic               adv;
  logic               v1;
  logic               v2;
  logic [2:0][31:0]   p1;
  logic [2:0][31:0]   p2;
  logic signed [64:0] prod [9];
  logic signed [36:0] acc [3];
  logic signed [36:0] acc_next [3];
  logic signed [31:0] ctr [3];
  logic signed [31:0] sat [3];
  logic [2:0]         clip;

  assign adv = !out_valid || out_ready;
  assign pop_ready = adv;
  assign ctr[0] = center_x;
  assign ctr[1] = center_y;
  assign ctr[2] = center_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_next[i] = 37'(ctr[i])
                  + 37'(rnd_shift(68'(prod[3*i]), 30))
                  + 37'(rnd_shift(68'(prod[3*i+1]), 30))
                  + 37'(rnd_shift(68'(prod[3*i+2]), 30));
      clip[i] = 1'b0;
      sat[i] = 32'(acc[i]);
      if (acc[i] > 37'sd2147483647) begin
        sat[i] = 32'sh7FFFFFFF;
        clip[i] = 1'b1;
      end else if (acc[i] < -37'sd2147483648) begin
        sat[i] = 32'sh80000000;
        clip[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= pop_item.p;
      p2 <= p1;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[3*i+j] <= $signed(coef.m[3*i+j]) * $signed(pop_item.d[j]);
        end
        acc[i] <= acc_next[i];
      end
      axis_zero <= coef.zero;
      if (coef.zero) begin
        rotated_x <= $signed(p2[0]);
        rotated_y <= $signed(p2[1]);
        rotated_z <= $signed(p2[2]);
        clipped <= 1'b0;
      end else begin
        rotated_x <= sat[0];
        rotated_y <= sat[1];
        rotated_z <= sat[2];
        clipped <= |clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= pop_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

`ifndef ASSERT_OFF
  a_zero_no_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && axis_zero |-> !clipped)
    else $error("clipped set on a zero-axis result");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (rotated_x == 32'sh7FFFFFFF || rotated_x == 32'sh80000000 ||
       rotated_y == 32'sh7FFFFFFF || rotated_y == 32'sh80000000 ||
       rotated_z == 32'sh7FFFFFFF || rotated_z == 32'sh80000000))
    else $error("clipped set with no coordinate at a rail");

  a_stage_reaches_out: assert property (@(posedge clk) disable iff (rst)
    v2 && adv |=> out_valid)
    else $error("pipeline item lost before the output register");
`endif

endmodule

// ===== rtl/core/axis_angle_point_rotation.sv =====
// Rotates one Q16.16 point per transfer about the configured axis through the
// configured center. The rotation matrix is built from the register values by a
// sequential coefficient unit (normalizing shift, bit-serial square root,
// three 62-step long divisions, a CORDIC of CORDIC_STAGES steps and fifteen
// products on one shared multiplier); it runs after reset and after every register
// write, and in_ready stays low until it is done. After that one point is accepted
// every cycle while the four-deep queue has room, the queue feeding a three-stage
// multiply/round/saturate pipeline that stalls while out_ready is low.
module axis_angle_point_rotation #(
  parameter int CORDIC_STAGES = aar_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rotated_x,
  output logic signed [31:0] rotated_y,
  output logic signed [31:0] rotated_z,
  output logic               axis_zero,
  output logic               clipped
);
  import aar_pkg::*;

  logic signed [31:0] axis_x, axis_y, axis_z;
  logic signed [31:0] center_x, center_y, center_z;
  logic signed [25:0] angle_deg;
  logic               start;
  logic               coef_ready;
  coef_t              coef;
  item_t              push_item;
  logic               push_ready;
  logic               pop_valid;
  logic               pop_ready;
  item_t              pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x <= '0;
      axis_y <= '0;
      axis_z <= 32'sd65536;
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      angle_deg <= '0;
      start <= 1'b1;
    end else begin
      start <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AXIS_X:   axis_x <= cfg_data;
          REG_AXIS_Y:   axis_y <= cfg_data;
          REG_AXIS_Z:   axis_z <= cfg_data;
          REG_CENTER_X: center_x <= cfg_data;
          REG_CENTER_Y: center_y <= cfg_data;
          REG_CENTER_Z: center_z <= cfg_data;
          REG_ANGLE:    angle_deg <= cfg_data[25:0];
          default: ;
        endcase
      end
    end
  end

  assign in_ready = coef_ready && !start && push_ready;

  always_comb begin
    push_item.p[0] = point_x;
    push_item.p[1] = point_y;
    push_item.p[2] = point_z;
    push_item.d[0] = 33'(point_x) - 33'(center_x);
    push_item.d[1] = 33'(point_y) - 33'(center_y);
    push_item.d[2] = 33'(point_z) - 33'(center_z);
  end

  aar_coef #(.CORDIC_STAGES(CORDIC_STAGES)) u_coef (
    .clk(clk), .rst(rst), .start(start),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .angle_deg(angle_deg), .coef(coef), .ready(coef_ready)
  );

  aar_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(in_valid && coef_ready && !start), .push_ready(push_ready),
    .push_item(push_item),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
  );

  aar_xform u_xform (
    .clk(clk), .rst(rst), .coef(coef),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
    .axis_zero(axis_zero), .clipped(clipped)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import aar_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_AXIS_X;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] rotated_x, rotated_y, rotated_z;
  logic axis_zero, clipped;

  always #4 clk = ~clk;

  axis_angle_point_rotation u_top (.*);

  typedef struct {
    logic signed [31:0] x, y, z;
    logic zero, clip;
  } rot_t;

  // directed stimulus row; has_exp marks rows with a hand-written result
  typedef struct {
    logic signed [31:0] px, py, pz;
    bit has_exp;
    rot_t exp_r;
  } row_t;

  // local copy of the configuration registers
  logic signed [31:0] ax_r, ay_r, az_r, cx_r, cy_r, cz_r;
  logic signed [25:0] ang_r;

  rot_t pending_rot[$];
  int mismatches = 0;
  int in_idle_pct = 0, out_idle_pct = 0;
  bit hold_out = 0;

  localparam longint ONE = 64'sd1 << 30;

  function automatic longint round_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sqrt_u64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[30] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};
    return t[i];
  endfunction

  function automatic rot_t rotate_point(logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pz);
    rot_t r;
    longint p[3], ctr[3], a[3], u[3], m[3][3], acc, c, s, t, xy, xz, yz, x, y, z, dx, dy, deg;
    longint unsigned mag[3], mx, n2, nrm;
    int sh;
    bit neg;
    p[0] = px; p[1] = py; p[2] = pz;
    ctr[0] = cx_r; ctr[1] = cy_r; ctr[2] = cz_r;
    a[0] = ax_r; a[1] = ay_r; a[2] = az_r;
    r.zero = 0; r.clip = 0;
    if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
      r.x = px; r.y = py; r.z = pz; r.zero = 1;
      return r;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (a[i] < 0) ? -a[i] : a[i];
      if (mag[i] > mx) mx = mag[i];
    end
    sh = 0;
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      sh++;
    end
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] <<= sh;
      n2 += mag[i] * mag[i];
    end
    nrm = sqrt_u64(n2);
    for (int i = 0; i < 3; i++) begin
      acc = ((mag[i] << 30) + (nrm >> 1)) / nrm;
      u[i] = (a[i] < 0) ? -acc : acc;
    end
    // angle fold to [-90, 90], CORDIC in Q2.30
    deg = ang_r;
    neg = 0;
    if (deg > 180 * 65536) deg -= 360 * 65536;
    else if (deg < -180 * 65536) deg += 360 * 65536;
    if (deg > 90 * 65536) begin
      deg -= 180 * 65536;
      neg = 1;
    end else if (deg < -90 * 65536) begin
      deg += 180 * 65536;
      neg = 1;
    end
    z = round_shift(deg * 74961321, 18);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    t = ONE - c;
    xy = q30_mul(q30_mul(u[0], u[1]), t);
    xz = q30_mul(q30_mul(u[0], u[2]), t);
    yz = q30_mul(q30_mul(u[1], u[2]), t);
    m[0][0] = q30_mul(q30_mul(u[0], u[0]), t) + c;
    m[0][1] = xy - q30_mul(u[2], s);
    m[0][2] = xz + q30_mul(u[1], s);
    m[1][0] = xy + q30_mul(u[2], s);
    m[1][1] = q30_mul(q30_mul(u[1], u[1]), t) + c;
    m[1][2] = yz - q30_mul(u[0], s);
    m[2][0] = xz - q30_mul(u[1], s);
    m[2][1] = yz + q30_mul(u[0], s);
    m[2][2] = q30_mul(q30_mul(u[2], u[2]), t) + c;
    for (int i = 0; i < 3; i++) begin
      acc = ctr[i];
      for (int j = 0; j < 3; j++) begin
        longint e;
        e = m[i][j];
        if (e > ONE) e = ONE;
        if (e < -ONE) e = -ONE;
        acc += round_shift(e * (p[j] - ctr[j]), 30);
      end
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647; r.clip = 1;
      end else if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648; r.clip = 1;
      end
      p[i] = p[i];
      if (i == 0) r.x = acc[31:0];
      else if (i == 1) r.y = acc[31:0];
      else r.z = acc[31:0];
    end
    return r;
  endfunction

  // write enable stays high across back-to-back writes; set_rotation drops it
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_AXIS_X: ax_r = val;
      REG_AXIS_Y: ay_r = val;
      REG_AXIS_Z: az_r = val;
      REG_CENTER_X: cx_r = val;
      REG_CENTER_Y: cy_r = val;
      REG_CENTER_Z: cz_r = val;
      REG_ANGLE: ang_r = val[25:0];
      default: ;
    endcase
  endtask

  task automatic set_rotation(logic [31:0] axx, logic [31:0] axy, logic [31:0] axz,
                              logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] ang);
    write_reg(REG_AXIS_X, axx);
    write_reg(REG_AXIS_Y, axy);
    write_reg(REG_AXIS_Z, axz);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_ANGLE, ang);
    cfg_we <= 1'b0;
  endtask

  // one transfer; valid stays high across back-to-back items
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit has_exp, rot_t e);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    pending_rot.push_back(has_exp ? e : rotate_point(x, y, z));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_rot.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      int md;
      rot_t nul;
      md = ($urandom_range(99) < 60) ? 1 : $urandom_range(0, 3);
      nul = '{default: 0};
      send_point(rand_coord(md), rand_coord(md), rand_coord(md), 0, nul);
    end
  endtask

  task automatic random_config;
    logic [31:0] v[7];
    for (int i = 0; i < 6; i++) v[i] = rand_coord($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) begin
      v[0] = 0; v[1] = 0; v[2] = 0;
    end
    v[6] = $urandom_range(0, 2 * 23592960) - 23592960;
    set_rotation(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
  endtask

  // output side: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_out && ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      rot_t e;
      if (pending_rot.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer x=%0d y=%0d z=%0d",
                                       rotated_x, rotated_y, rotated_z);
      end else begin
        e = pending_rot.pop_front();
        if (rotated_x !== e.x || rotated_y !== e.y || rotated_z !== e.z ||
            axis_zero !== e.zero || clipped !== e.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d z%0b c%0b got %0d %0d %0d z%0b c%0b",
                     e.x, e.y, e.z, e.zero, e.clip,
                     rotated_x, rotated_y, rotated_z, axis_zero, clipped);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("axis_angle_point_rotation verification failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    rot_t nul;
    nul = '{default: 0};
    ax_r = 0; ay_r = 0; az_r = 65536; cx_r = 0; cy_r = 0; cz_r = 0; ang_r = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // after reset: zero angle about +z; CORDIC cosine is not exactly one
    rows.push_back('{32'sd65536, -32'sd131072, 32'sd7, 0, nul});
    rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'sd0, 0, nul});
    foreach (rows[i])
      send_point(rows[i].px, rows[i].py, rows[i].pz, rows[i].has_exp, rows[i].exp_r);
    drain();
    // zero axis: pass-through flagged
    set_rotation(0, 0, 0, 32'h1234_0000, 0, 0, 90 << 16);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, -32'sd5, 1, '{32'h8000_0000, 32'h7FFF_FFFF, -32'sd5, 1, 0});
    send_point(32'sd3, 32'sd0, 32'hFFFF_FFFF, 1, '{32'sd3, 0, 32'hFFFF_FFFF, 1, 0});
    drain();
    // extremes: 180 degrees about x with saturating points, then -360, +360, -1 LSB
    set_rotation(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 180 << 16);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, nul);
    send_point(0, 0, 0, 0, nul);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, nul);
    drain();
    set_rotation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, -32'sd23592960);
    send_point(32'sd65536, 32'sd0, 32'sd0, 0, nul);
    send_point(32'h4000_0000, 32'hC000_0000, 32'h1, 0, nul);
    drain();
    set_rotation(32'sd1, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 23592960);
    send_point(32'sd1000, -32'sd1000, 32'sd5, 0, nul);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, nul);
    drain();
    set_rotation(0, 32'sd65536, 0, 32'sd65536, 0, 0, 32'h03FF_FFFF);
    send_point(32'sd65536, 32'sd65536, 32'sd65536, 0, nul);
    drain();
    // random phases with changing rotations; each phase ends with a full drain
    for (int ph = 0; ph < 18; ph++) begin
      if (ph < 6) begin
        in_idle_pct = 35; out_idle_pct = 73;
      end else if (ph < 12) begin
        in_idle_pct = 73; out_idle_pct = 35;
      end else begin
        in_idle_pct = 0; out_idle_pct = 0;
      end
      random_config();
      if (ph == 13) begin
        hold_out = 1;
        fork
          begin
            repeat (200) @(posedge clk);
            hold_out = 0;
          end
        join_none
      end
      random_points(110);
      drain();
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("axis_angle_point_rotation verification clean");
    else $display("axis_angle_point_rotation verification failed");
    $finish;
  end

endmodule
